/* rtl/button_gesture_classifier_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button gesture classifier
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked every clock outside reset.
`define BGC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Antecedent this cycle implies consequent next cycle.
`define BGC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BGC_ASSERT(name, clk, rst_n, prop)
`define BGC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/bgc_pkg.sv */
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int TIMER_BITS  = 16;
  localparam int NUM_BUTTONS = 3;
  localparam int LANES       = 3;  // buttons that have input fields
  localparam int ACTIVE      = (NUM_BUTTONS < LANES) ? NUM_BUTTONS : LANES;

  localparam int HOLD_W  = 16;
  localparam int DBL_W   = 16;
  localparam int DRAG_W  = 22;
  localparam int CFG_W   = 22;
  localparam int MOVE_W  = 11;
  localparam int SQ_W    = 2 * MOVE_W - 1;  // one square, magnitude <= 2^(MOVE_W-1)
  localparam int CMP_W   = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2,
    ST_DRAGGING = 2'd3
  } gstate_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CLICK   = 3'd3,
    EV_DOUBLE  = 3'd4
  } gevent_t;

  typedef enum logic [1:0] {
    CFG_HOLD_TICKS  = 2'd0,
    CFG_DBL_TICKS   = 2'd1,
    CFG_DRAG_DIST   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_ticks;
    logic [DBL_W-1:0]  double_click_ticks;
  } lane_cfg_t;

endpackage

/* rtl/bgc_in_if.sv */
// ----------------------------------------------------------------------------
// bgc_in_if
// Frame tick channel: button levels and pointer displacement.
// ----------------------------------------------------------------------------
interface bgc_in_if;
  logic        valid;
  logic        ready;
  logic        left_down;
  logic        right_down;
  logic        middle_down;
  logic signed [10:0] move_x;
  logic signed [10:0] move_y;

  modport source (output valid, left_down, right_down, middle_down, move_x, move_y,
                  input ready);
  modport sink   (input valid, left_down, right_down, middle_down, move_x, move_y,
                  output ready);
endinterface

/* rtl/bgc_out_if.sv */
// ----------------------------------------------------------------------------
// bgc_out_if
// Result channel: per-button gesture state and event.
// ----------------------------------------------------------------------------
interface bgc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] left_state;
  logic [2:0] left_event;
  logic [1:0] right_state;
  logic [2:0] right_event;
  logic [1:0] middle_state;
  logic [2:0] middle_event;

  modport source (output valid, left_state, left_event, right_state, right_event,
                  middle_state, middle_event, input ready);
  modport sink   (input valid, left_state, left_event, right_state, right_event,
                  middle_state, middle_event, output ready);
endinterface

/* rtl/bgc_motion.sv */
// ----------------------------------------------------------------------------
// bgc_motion
// Squared displacement of one frame compared against the drag limit.
// ----------------------------------------------------------------------------
module bgc_motion (
  input  logic signed [10:0] move_x,
  input  logic signed [10:0] move_y,
  input  logic [21:0]        drag_dist_sq,
  output logic               far
);
  import bgc_pkg::*;

  logic [MOVE_W-1:0] mag_x;
  logic [MOVE_W-1:0] mag_y;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [DRAG_W-1:0] sum_sq;

  // -1024 negates to the unsigned pattern 1024, which is the right magnitude
  assign mag_x  = move_x[MOVE_W-1] ? MOVE_W'(-move_x) : MOVE_W'(move_x);
  assign mag_y  = move_y[MOVE_W-1] ? MOVE_W'(-move_y) : MOVE_W'(move_y);
  assign sq_x   = SQ_W'(mag_x) * SQ_W'(mag_x);
  assign sq_y   = SQ_W'(mag_y) * SQ_W'(mag_y);
  assign sum_sq = DRAG_W'(sq_x) + DRAG_W'(sq_y);
  assign far    = (sum_sq >= drag_dist_sq);

endmodule

/* rtl/bgc_lane.sv */
// ----------------------------------------------------------------------------
// bgc_lane
// Gesture state and timers of one button, updated once per frame.
// ----------------------------------------------------------------------------
module bgc_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               down,
  input  logic               far,
  input  bgc_pkg::lane_cfg_t cfg,
  output bgc_pkg::gstate_t   state_nxt,
  output bgc_pkg::gevent_t   ev_nxt
);
  import bgc_pkg::*;

  `include "button_gesture_classifier_core_assert.svh"

  gstate_t state_r;
  timer_t  press_age_r, press_age_nxt;
  timer_t  click_age_r, click_age_nxt;
  timer_t  click_inc, press_inc;

  assign click_inc = (click_age_r == '1) ? click_age_r : click_age_r + 1'b1;
  assign press_inc = (press_age_r == '1) ? press_age_r : press_age_r + 1'b1;

  always_comb begin
    state_nxt     = ST_IDLE;
    ev_nxt        = EV_NONE;
    press_age_nxt = '0;
    click_age_nxt = click_inc;
    if (down) begin
      if (state_r == ST_IDLE) begin
        ev_nxt        = EV_PRESS;
        press_age_nxt = '0;
      end else begin
        press_age_nxt = press_inc;
      end
      if (far) begin
        state_nxt = ST_DRAGGING;
      end else if (CMP_W'(press_age_nxt) > CMP_W'(cfg.hold_ticks)) begin
        state_nxt = ST_HELD;
      end else begin
        state_nxt = ST_PRESSED;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          ev_nxt = EV_NONE;
        end
        ST_PRESSED: begin
          ev_nxt = (CMP_W'(click_inc) <= CMP_W'(cfg.double_click_ticks)) ?
                   EV_DOUBLE : EV_CLICK;
          click_age_nxt = '0;
        end
        default: begin
          ev_nxt = EV_RELEASE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      press_age_r <= '0;
      click_age_r <= '1;
    end else if (adv) begin
      state_r     <= state_nxt;
      press_age_r <= press_age_nxt;
      click_age_r <= click_age_nxt;
    end
  end

  `BGC_ASSERT(a_idle_no_age, clk, rst_n, (state_r == ST_IDLE) |-> (press_age_r == '0))
  `BGC_ASSERT_NEXT(a_click_restart, clk, rst_n, adv && (ev_nxt == EV_CLICK || ev_nxt == EV_DOUBLE), click_age_r == '0)
  `BGC_ASSERT_NEXT(a_hold_when_stalled, clk, rst_n, !adv, $stable(state_r) && $stable(click_age_r))

endmodule

/* rtl/button_gesture_classifier_core.sv */
// ----------------------------------------------------------------------------
// button_gesture_classifier_core
// Click, hold, drag and double-click detection for three buttons.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+---------------------------------------
//   in_ch    | in  | valid/ready       | 3 button levels, move_x, move_y (s11)
//   out_ch   | out | valid/ready       | state (2b) and event (3b) per button
//   cfg_*    | in  | we, no back-press | index 0 hold, 1 double click, 2 drag
//
// Two register stages: an input register and a result register, with the
// squared-distance compare and per-button update in between. out_ch.valid rises
// as a frame enters the result register; one frame per cycle if out_ch.ready.
// Button state advances when a frame moves into the result register, so a
// stalled output holds both the frame in flight and the button state.
// rst_n is synchronous: buttons idle, press age zero, click age saturated,
// registers back to 30 / 15 / 16.
// ----------------------------------------------------------------------------
module button_gesture_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  bgc_in_if.sink      in_ch,
  bgc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_wdata
);
  import bgc_pkg::*;

  `include "button_gesture_classifier_core_assert.svh"

  // configuration registers
  logic [HOLD_W-1:0] hold_ticks_r;
  logic [DBL_W-1:0]  dbl_ticks_r;
  logic [DRAG_W-1:0] drag_dist_r;
  lane_cfg_t         lane_cfg;

  // input register
  logic              s0_valid_r;
  logic [LANES-1:0]  s0_down_r;
  logic signed [MOVE_W-1:0] s0_mx_r;
  logic signed [MOVE_W-1:0] s0_my_r;

  // result register
  logic              out_valid_r;
  gstate_t           out_st_r [LANES];
  gevent_t           out_ev_r [LANES];

  gstate_t           st_nxt [LANES];
  gevent_t           ev_nxt [LANES];
  logic              far;
  logic              adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_W'(30);
      dbl_ticks_r  <= DBL_W'(15);
      drag_dist_r  <= DRAG_W'(16);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HOLD_TICKS: hold_ticks_r <= cfg_wdata[HOLD_W-1:0];
        CFG_DBL_TICKS:  dbl_ticks_r  <= cfg_wdata[DBL_W-1:0];
        CFG_DRAG_DIST:  drag_dist_r  <= cfg_wdata[DRAG_W-1:0];
        default: begin
          // unused index: write dropped
        end
      endcase
    end
  end

  assign lane_cfg.hold_ticks         = hold_ticks_r;
  assign lane_cfg.double_click_ticks = dbl_ticks_r;

  // frame moves from the input register to the result register
  assign adv         = s0_valid_r && (!out_valid_r || out_ch.ready);
  // input register refills whenever it is empty or draining this cycle
  assign in_ch.ready = !s0_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_down_r <= {in_ch.middle_down, in_ch.right_down, in_ch.left_down};
      s0_mx_r   <= in_ch.move_x;
      s0_my_r   <= in_ch.move_y;
    end
  end

  bgc_motion u_motion (
    .move_x       (s0_mx_r),
    .move_y       (s0_my_r),
    .drag_dist_sq (drag_dist_r),
    .far          (far)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < ACTIVE) begin : g_on
      bgc_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .down      (s0_down_r[g]),
        .far       (far),
        .cfg       (lane_cfg),
        .state_nxt (st_nxt[g]),
        .ev_nxt    (ev_nxt[g])
      );
    end else begin : g_off
      // button not fitted: reports idle, no event
      assign st_nxt[g] = ST_IDLE;
      assign ev_nxt[g] = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_st_r <= st_nxt;
      out_ev_r <= ev_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_state   = out_st_r[0];
  assign out_ch.left_event   = out_ev_r[0];
  assign out_ch.right_state  = out_st_r[1];
  assign out_ch.right_event  = out_ev_r[1];
  assign out_ch.middle_state = out_st_r[2];
  assign out_ch.middle_event = out_ev_r[2];

  `BGC_ASSERT_NEXT(a_s0_kept, clk, rst_n, s0_valid_r && !adv, s0_valid_r)
  `BGC_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, adv, out_valid_r)
  `BGC_ASSERT_NEXT(a_out_kept, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r)

endmodule
